>>> design/wilm_pkg.sv
// Shared types and constants of the windowed idle load meter.
`timescale 1ns / 1ps
package wilm_pkg;

    localparam int DUR_W     = 48;
    localparam int SUM_W     = 54;
    localparam int FRAC_W    = 16;
    localparam int SHORT_WIN = 10;
    localparam int MID_WIN   = 25;
    localparam int MAX_LONG  = 50;
    localparam int CNT_W     = 5;

    // Register indexes on the configuration port
    localparam logic REG_IDLE_RUN = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_S,
        S_RD_M,
        S_RD_L,
        S_UPD,
        S_MUL,
        S_DIV,
        S_WAIT,
        S_OUT
    } wilm_state_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] base;
    } wilm_div_req_t;

    typedef struct packed {
        logic              done;
        logic [FRAC_W-1:0] quot;
    } wilm_div_rsp_t;

endpackage

>>> design/wilm_hist_mem.sv
// History memory of clamped durations: one write port, one registered read port.
`timescale 1ns / 1ps
module wilm_hist_mem
    import wilm_pkg::*;
#(
    parameter int Depth = 50,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [DUR_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [DUR_W-1:0] rd_data
);

    logic [DUR_W-1:0] mem [Depth];
    logic [DUR_W-1:0] rd_data_reg;

    // Store the newest duration
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/wilm_divider.sv
// Iterative Q0.16 fraction unit: (sum - base) / sum, one quotient bit per cycle.
`timescale 1ns / 1ps
module wilm_divider
    import wilm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  wilm_div_req_t req,
    output wilm_div_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  div_reg, div_next;
    logic [FRAC_W-1:0] q_reg, q_next;
    logic [SUM_W:0]    trial;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        q_reg   <= q_next;
    end

    // Start, special cases and one restoring step per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        q_next    = q_reg;
        trial     = {rem_reg, 1'b0};
        if (req.start)
        begin
            div_next = req.sum;
            rem_next = req.sum - req.base;
            if (req.sum == '0 || req.base > req.sum)
            begin
                q_next    = '0;
                done_next = 1'b1;
            end
            else if (req.base == '0)
            begin
                q_next    = '1;
                done_next = 1'b1;
            end
            else
            begin
                q_next    = '0;
                busy_next = 1'b1;
                cnt_next  = CNT_W'(FRAC_W);
            end
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = SUM_W'(trial - {1'b0, div_reg});
                q_next   = {q_reg[FRAC_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = SUM_W'(trial);
                q_next   = {q_reg[FRAC_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

endmodule

>>> design/windowed_idle_load_meter.sv
// Top level: sliding-window idle load meter with history memory and shared divider.
// Each accepted item passes the history reads and the sum update, then four passes of the one divider,
//   one per fraction, of 16 restoring steps each in the general case and none for a special case.
// Three history reads and one write per item; a new item is taken only after the last result is loaded.
// A finished result waits in the output register while the next item is taken.
// Reset clears the sums, the sample count and the write pointer; history entries not yet
//   written are masked by the sample count, so the memory needs no clearing pass.
`timescale 1ns / 1ps
module windowed_idle_load_meter
    import wilm_pkg::*;
#(
    parameter int HISTORY_DEPTH = 50
) (
    input  logic              clk,
    input  logic              rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    // input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [DUR_W-1:0]  measured_cycles,
    // output channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DUR_W-1:0]  raw_cycles,
    output logic [DUR_W-1:0]  clamped_cycles,
    output logic [FRAC_W-1:0] load_now,
    output logic [FRAC_W-1:0] load_short,
    output logic [FRAC_W-1:0] load_mid,
    output logic [FRAC_W-1:0] load_long
);

    localparam int LongWin = (HISTORY_DEPTH < MAX_LONG) ? HISTORY_DEPTH : MAX_LONG;
    localparam int AW      = $clog2(LongWin);
    localparam int CW      = $clog2(LongWin + 1);
    localparam int PW      = CW + DUR_W;

    wilm_state_t       state_reg, state_next;
    logic [DUR_W-1:0]  idle_reg, idle_next;
    logic [SUM_W-1:0]  short_reg, short_next;
    logic [SUM_W-1:0]  mid_reg, mid_next;
    logic [SUM_W-1:0]  long_reg, long_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     wp_reg, wp_next;
    logic [1:0]        lane_reg, lane_next;
    logic              out_valid_reg, out_valid_next;

    logic [DUR_W-1:0]  raw_reg, raw_next;
    logic [DUR_W-1:0]  dur_reg, dur_next;
    logic [SUM_W-1:0]  base_reg, base_next;
    logic [SUM_W-1:0]  sel_reg, sel_next;
    logic [FRAC_W-1:0] frac_reg [4];

    logic [DUR_W-1:0]  out_raw_reg, out_dur_reg;
    logic [FRAC_W-1:0] out_now_reg, out_short_reg, out_mid_reg, out_long_reg;
    logic              out_load;

    logic              wr_en, rd_en;
    logic [AW-1:0]     rd_addr;
    logic [DUR_W-1:0]  rd_data, old_dur;
    logic [AW-1:0]     addr_s, addr_m, addr_l;
    logic [CW-1:0]     n_sel;
    logic [PW-1:0]     prod;
    logic              cfg_wr;

    wilm_div_req_t     div_req;
    wilm_div_rsp_t     div_rsp;

    // Slot k entries back from the newest: (wp - 1 - k) mod LongWin
    function automatic logic [AW-1:0] slot_back(input logic [AW-1:0] wp, input int k);
        logic [AW:0] t;
        t = {1'b0, wp} + (AW+1)'(LongWin - 1 - k);
        if (t >= (AW+1)'(LongWin))
        begin
            t = t - (AW+1)'(LongWin);
        end
        return t[AW-1:0];
    endfunction

    assign addr_s = slot_back(wp_reg, SHORT_WIN - 1);
    assign addr_m = slot_back(wp_reg, MID_WIN - 1);
    assign addr_l = slot_back(wp_reg, LongWin - 1);

    // Configuration register
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_IDLE_RUN) ? {16'b0, idle_reg} : 64'b0;

    always_comb
    begin
        idle_next = idle_reg;
        if (cfg_wr && paddr[3] == REG_IDLE_RUN)
        begin
            idle_next = pwdata[DUR_W-1:0];
        end
    end

    // History memory
    wilm_hist_mem #(
        .Depth (LongWin),
        .AW    (AW)
    ) u_hist (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (dur_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared fraction unit
    wilm_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Window size of the current lane
    always_comb
    begin
        case (lane_reg)
            2'd0:    n_sel = CW'(1);
            2'd1:    n_sel = (count_reg < CW'(SHORT_WIN)) ? count_reg : CW'(SHORT_WIN);
            2'd2:    n_sel = (count_reg < CW'(MID_WIN)) ? count_reg : CW'(MID_WIN);
            default: n_sel = count_reg;
        endcase
    end

    assign prod = {{DUR_W{1'b0}}, n_sel} * {{CW{1'b0}}, idle_reg};

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idle_reg      <= DUR_W'(64'd2000000000);
            short_reg     <= '0;
            mid_reg       <= '0;
            long_reg      <= '0;
            count_reg     <= '0;
            wp_reg        <= '0;
            lane_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idle_reg      <= idle_next;
            short_reg     <= short_next;
            mid_reg       <= mid_next;
            long_reg      <= long_next;
            count_reg     <= count_next;
            wp_reg        <= wp_next;
            lane_reg      <= lane_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working payload registers
    always_ff @(posedge clk)
    begin
        raw_reg  <= raw_next;
        dur_reg  <= dur_next;
        base_reg <= base_next;
        sel_reg  <= sel_next;
        if (state_reg == S_WAIT && div_rsp.done)
        begin
            frac_reg[lane_reg] <= div_rsp.quot;
        end
    end

    // Output registers
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_raw_reg   <= raw_reg;
            out_dur_reg   <= dur_reg;
            out_now_reg   <= frac_reg[0];
            out_short_reg <= frac_reg[1];
            out_mid_reg   <= frac_reg[2];
            out_long_reg  <= frac_reg[3];
        end
    end

    // Sequencer: read oldest entries, update sums, write back, then four fractions
    always_comb
    begin
        state_next     = state_reg;
        short_next     = short_reg;
        mid_next       = mid_reg;
        long_next      = long_reg;
        count_next     = count_reg;
        wp_next        = wp_reg;
        lane_next      = lane_reg;
        raw_next       = raw_reg;
        dur_next       = dur_reg;
        base_next      = base_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_load       = 1'b0;
        in_stall       = 1'b1;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = addr_s;
        old_dur        = '0;
        div_req.start  = 1'b0;
        div_req.sum    = sel_reg;
        div_req.base   = base_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    raw_next   = measured_cycles;
                    dur_next   = (measured_cycles < idle_reg) ? idle_reg : measured_cycles;
                    state_next = S_RD_S;
                end
            end
            S_RD_S:
            begin
                rd_en      = 1'b1;
                rd_addr    = addr_s;
                state_next = S_RD_M;
            end
            S_RD_M:
            begin
                rd_en      = 1'b1;
                rd_addr    = addr_m;
                old_dur    = (count_reg > CW'(SHORT_WIN - 1)) ? rd_data : '0;
                short_next = short_reg + {6'b0, dur_reg} - {6'b0, old_dur};
                state_next = S_RD_L;
            end
            S_RD_L:
            begin
                rd_en      = 1'b1;
                rd_addr    = addr_l;
                old_dur    = (count_reg > CW'(MID_WIN - 1)) ? rd_data : '0;
                mid_next   = mid_reg + {6'b0, dur_reg} - {6'b0, old_dur};
                state_next = S_UPD;
            end
            S_UPD:
            begin
                old_dur   = (count_reg > CW'(LongWin - 1)) ? rd_data : '0;
                long_next = long_reg + {6'b0, dur_reg} - {6'b0, old_dur};
                wr_en     = 1'b1;
                wp_next   = (wp_reg == AW'(LongWin - 1)) ? '0 : wp_reg + 1'b1;
                if (count_reg < CW'(LongWin))
                begin
                    count_next = count_reg + 1'b1;
                end
                lane_next  = 2'd0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                base_next = SUM_W'(prod);
                case (lane_reg)
                    2'd0:    sel_next = {6'b0, dur_reg};
                    2'd1:    sel_next = short_reg;
                    2'd2:    sel_next = mid_reg;
                    default: sel_next = long_reg;
                endcase
                state_next = S_DIV;
            end
            S_DIV:
            begin
                div_req.start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (lane_reg == 2'd3)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        lane_next  = lane_reg + 1'b1;
                        state_next = S_MUL;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign raw_cycles     = out_raw_reg;
    assign clamped_cycles = out_dur_reg;
    assign load_now       = out_now_reg;
    assign load_short     = out_short_reg;
    assign load_mid       = out_mid_reg;
    assign load_long      = out_long_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(LongWin))
        else $error("sample count beyond long window");

    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg < AW'(LongWin))
        else $error("write pointer out of range");

    a_write_then_frac: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (state_reg == S_MUL && lane_reg == 2'd0))
        else $error("history write not followed by first fraction");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result raised outside output state");

    a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> state_reg == S_WAIT)
        else $error("divider start without wait");

endmodule
